// ----- src/lesf_pkg.sv -----
// ----------------------------------------------------------------------------
// lesf_pkg: shared definitions for the largest empty square finder
// Register map, reset values and field widths used by the core.
// ----------------------------------------------------------------------------
package lesf_pkg;

	// Default sizing of the line buffer and row counter
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_ROWS  = 65536;

	// Configuration register indexes (byte address is 4 * index)
	localparam logic REG_GRID_WIDTH = 1'b0;
	localparam logic REG_OBSTACLE   = 1'b1;

	// Register field widths and reset values
	localparam int          CFG_WIDTH_W   = 11;
	localparam int          CHAR_W        = 8;
	localparam logic [10:0] GRID_WIDTH_RST = 11'd1;
	localparam logic [7:0]  OBSTACLE_RST   = 8'd111;

	// Result field widths
	localparam int TOP_ROW_W  = 16;
	localparam int LEFT_COL_W = 10;
	localparam int SIDE_W     = 11;
	localparam int OUT_DATA_W = 40;

endpackage

// ----- src/largest_empty_square_finder_core.sv -----
// ----------------------------------------------------------------------------
// largest_empty_square_finder_core
// Streams grid cells in row-major order and reports the top-left corner and
// side of the largest square without obstacle cells, one result per grid.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                          | Content
//  ---------+-----------+----------------------------------+----------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tlast| cell char, last cell
//  m_*      | out       | m_tvalid m_tready m_tdata        | row, column, side
//  APB      | in        | psel penable pwrite paddr pwdata | grid width, obstacle
//
//  One cell is taken per cycle while s_tready is high. Each cell reads the
//  line buffer on the accept edge and writes its size back when it leaves
//  stage 1; a same-column read right behind a write (grid width of one) is
//  forwarded. After reset a clearing pass zeroes the line buffer, during
//  which s_tready is low; configuration writes are taken throughout. Apart
//  from that pass, the input stalls only when the last cell of a grid waits
//  for an output register that still holds an untaken result.
//
module largest_empty_square_finder_core #(
	parameter int MAX_WIDTH = lesf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_ROWS  = lesf_pkg::DEF_MAX_ROWS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input cells
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [lesf_pkg::CHAR_W-1:0]             s_tdata,   // [7:0] cell_char
	input  logic                                    s_tlast,   // last_cell
	// results
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [lesf_pkg::OUT_DATA_W-1:0]         m_tdata,   // [15:0] top_row,
	                                                           // [25:16] left_col,
	                                                           // [36:26] side, rest 0
	// configuration
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [2:0]                              paddr,
	input  logic [31:0]                             pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);
	import lesf_pkg::*;

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SZ_W   = $clog2(MAX_WIDTH + 1);
	localparam int WCMP_W = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;

	// configuration registers
	logic [CFG_WIDTH_W-1:0] grid_width_q;
	logic [CHAR_W-1:0]      obstacle_q;

	// line buffer
	logic [SZ_W-1:0] line_mem [MAX_WIDTH];
	logic [SZ_W-1:0] up_mem_s1;

	// clearing pass
	logic             clr_q;
	logic [COL_W-1:0] clr_addr_q;

	// accept-side counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// stage 1
	logic             valid_s1;
	logic             last_s1;
	logic             blocked_s1;
	logic             first_row_s1;
	logic             row_end_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             fwd_s1;
	logic [SZ_W-1:0]  fwd_size_s1;

	// running square state
	logic [SZ_W-1:0]  left_q;
	logic [SZ_W-1:0]  diag_q;
	logic [SZ_W-1:0]  best_side_q;
	logic [ROW_W-1:0] best_row_q;
	logic [COL_W-1:0] best_col_q;

	// output register
	logic                  out_valid_q;
	logic [TOP_ROW_W-1:0]  out_row_q;
	logic [LEFT_COL_W-1:0] out_col_q;
	logic [SIDE_W-1:0]     out_side_q;

	logic              accept;
	logic              stall_s1;
	logic              adv_s1;
	logic              cfg_wr;
	logic [WCMP_W-1:0] eff_width;
	logic              row_end;
	logic [SZ_W-1:0]   up;
	logic [SZ_W-1:0]   min_lu;
	logic [SZ_W-1:0]   min3;
	logic [SZ_W-1:0]   size;
	logic              new_best;
	logic [SZ_W-1:0]   nxt_best_side;
	logic [ROW_W-1:0]  nxt_best_row;
	logic [COL_W-1:0]  nxt_best_col;

	// handshake and configuration decode
	assign stall_s1 = valid_s1 && last_s1 && out_valid_q && !m_tready;
	assign adv_s1   = valid_s1 && !stall_s1;
	assign s_tready = !clr_q && !stall_s1;
	assign accept   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	// read back the addressed register
	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH: prdata = 32'(grid_width_q);
			REG_OBSTACLE:   prdata = 32'(obstacle_q);
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RST;
			obstacle_q   <= OBSTACLE_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_GRID_WIDTH: grid_width_q <= pwdata[CFG_WIDTH_W-1:0];
				REG_OBSTACLE:   obstacle_q   <= pwdata[CHAR_W-1:0];
				default:        ;
			endcase
		end
	end

	// clamp the row width to 1..MAX_WIDTH and detect the row end
	always_comb begin
		if (grid_width_q == '0) begin
			eff_width = WCMP_W'(1);
		end else if (WCMP_W'(grid_width_q) > WCMP_W'(MAX_WIDTH)) begin
			eff_width = WCMP_W'(MAX_WIDTH);
		end else begin
			eff_width = WCMP_W'(grid_width_q);
		end
		row_end = (WCMP_W'(col_q) + WCMP_W'(1)) >= eff_width;
	end

	// advance column and row counters on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				if (row_q != ROW_W'(MAX_ROWS - 1)) begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// sweep the line buffer to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + COL_W'(1);
			if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// line buffer: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (clr_q) begin
			line_mem[clr_addr_q] <= '0;
		end else if (adv_s1) begin
			line_mem[col_s1] <= size;
		end
		if (accept) begin
			up_mem_s1 <= line_mem[col_q];
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, with forwarding of a write to the column just read
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1      <= s_tlast;
			blocked_s1   <= (s_tdata == obstacle_q);
			first_row_s1 <= (row_q == '0);
			row_end_s1   <= row_end;
			col_s1       <= col_q;
			row_s1       <= row_q;
			fwd_s1       <= adv_s1 && (col_s1 == col_q);
			fwd_size_s1  <= size;
		end
	end

	// size of the current cell and best-square update
	always_comb begin
		if (first_row_s1) begin
			up = '0;
		end else if (fwd_s1) begin
			up = fwd_size_s1;
		end else begin
			up = up_mem_s1;
		end
		min_lu = (left_q < up) ? left_q : up;
		min3   = (diag_q < min_lu) ? diag_q : min_lu;
		size   = blocked_s1 ? '0 : min3 + SZ_W'(1);

		new_best      = size > best_side_q;
		nxt_best_side = best_side_q;
		nxt_best_row  = best_row_q;
		nxt_best_col  = best_col_q;
		if (new_best) begin
			nxt_best_side = size;
			nxt_best_row  = row_s1 + ROW_W'(1) - ROW_W'(size);
			nxt_best_col  = col_s1 + COL_W'(1) - COL_W'(size);
		end
	end

	// hold neighbor sizes and the best square; drop them at the grid end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_side_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				left_q      <= '0;
				diag_q      <= '0;
				best_side_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				best_side_q <= nxt_best_side;
				best_row_q  <= nxt_best_row;
				best_col_q  <= nxt_best_col;
				if (row_end_s1) begin
					left_q <= '0;
					diag_q <= '0;
				end else begin
					left_q <= size;
					diag_q <= up;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_row_q  <= TOP_ROW_W'(nxt_best_row);
			out_col_q  <= LEFT_COL_W'(nxt_best_col);
			out_side_q <= SIDE_W'(nxt_best_side);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_side_q, out_col_q, out_row_q};

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for largest_empty_square_finder_core
// Streams grid cells into the core, predicts the largest obstacle-free square
// of each grid with a line-buffer model of its own, and checks every result
// item field by field. Covers register extremes, width changes inside a grid,
// long output hold-off and the widest row, under random idling.
// ----------------------------------------------------------------------------
module tb;
	import lesf_pkg::*;

	localparam int MAX_W         = DEF_MAX_WIDTH;
	localparam int MAX_R         = DEF_MAX_ROWS;
	localparam int ITEMS         = 1850;
	localparam int TAIL_ITEMS    = MAX_W + 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 400;
	localparam int RUN_LIMIT_NS  = 5000000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} cell_t;

	// one result item, laid out as on m_tdata (top_row in the lowest bits)
	typedef struct packed {
		logic [2:0]         pad;
		logic [SIDE_W-1:0]     side;
		logic [LEFT_COL_W-1:0] left_col;
		logic [TOP_ROW_W-1:0]  top_row;
	} square_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [CHAR_W-1:0]     s_tdata = '0;   // [7:0] cell_char
	logic                  s_tlast = 1'b0; // last_cell
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [15:0] top_row, [25:16] left_col,
	                                       // [36:26] side, rest 0
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [2:0]            paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	largest_empty_square_finder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// stimulus and expectation stores
	cell_t   cells_pending[$];
	square_t squares_due[$];
	int      cells_queued = 0;
	int      cells_taken = 0;
	int      squares_seen = 0;
	int      reg_writes = 0;
	int      mismatches = 0;
	int      src_idle_pct = 0;
	int      dst_idle_pct = 0;

	// long receiver hold-off, requested once by the stimulus
	bit      hold_req = 1'b0;
	bit      hold_done = 1'b0;
	int      hold_left = 0;

	// predictor copy of the registers and of the search state
	logic [CFG_WIDTH_W-1:0] grid_width_reg = GRID_WIDTH_RST;
	logic [CHAR_W-1:0]      obstacle_reg = OBSTACLE_RST;
	logic [10:0]            line_sizes [MAX_W] = '{default: '0};
	logic [10:0]            left_sz = '0;
	logic [10:0]            diag_sz = '0;
	logic [9:0]             col_cnt = '0;
	logic [15:0]            row_cnt = '0;
	logic [10:0]            best_side = '0;
	logic [15:0]            best_row = '0;
	logic [9:0]             best_col = '0;

	function automatic void flag_mismatch(string what, longint unsigned want,
			longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s at %0t: expected %0d, got %0d", what, $realtime, want,
				got);
	endfunction

	// Advance the square search by one cell; queue the square on the last cell
	function automatic void step_square_search(input logic [7:0] ch, input logic last);
		int      width;
		int      col;
		int      up;
		int      least;
		int      size;
		square_t found;
		width = grid_width_reg;
		if (width == 0)
			width = 1;
		if (width > MAX_W)
			width = MAX_W;
		col = col_cnt;
		if (col >= MAX_W)
			col = MAX_W - 1;
		up = (row_cnt == 0) ? 0 : line_sizes[col];
		least = (up < diag_sz) ? up : diag_sz;
		if (left_sz < least)
			least = left_sz;
		size = (ch == obstacle_reg) ? 0 : least + 1;
		// keep the first strictly larger square only
		if (size > best_side) begin
			best_side = 11'(size);
			best_row = 16'(row_cnt + 1 - size);
			best_col = 10'(col + 1 - size);
		end
		line_sizes[col] = 11'(size);
		if (col + 1 >= width) begin
			col_cnt = '0;
			left_sz = '0;
			diag_sz = '0;
			if (row_cnt < MAX_R - 1)
				row_cnt++;
		end else begin
			col_cnt = 10'(col + 1);
			left_sz = 11'(size);
			diag_sz = 11'(up);
		end
		if (last) begin
			found.pad = '0;
			found.side = best_side;
			found.left_col = best_col;
			found.top_row = best_row;
			squares_due.push_back(found);
			left_sz = '0;
			diag_sz = '0;
			col_cnt = '0;
			row_cnt = '0;
			best_side = '0;
			best_row = '0;
			best_col = '0;
		end
	endfunction

	// Drive cells: hold an item until taken, idle at random between items
	always @(posedge clk) begin : drive_cells
		cell_t nxt;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (cells_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				nxt = cells_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.ch;
				s_tlast <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Count down the long hold-off
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Stall the result side at random, and fully during the hold-off
	always @(posedge clk) begin
		m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= dst_idle_pct);
	end

	// Check result items, then predict from accepted cells
	always @(posedge clk) begin : watch_stream
		square_t got;
		square_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				squares_seen++;
				if (squares_due.size() == 0) begin
					flag_mismatch("unexpected result side", 0, got.side);
				end else begin
					want = squares_due.pop_front();
					if (got.top_row !== want.top_row)
						flag_mismatch("top_row", want.top_row, got.top_row);
					if (got.left_col !== want.left_col)
						flag_mismatch("left_col", want.left_col, got.left_col);
					if (got.side !== want.side)
						flag_mismatch("side", want.side, got.side);
					if (got.pad !== want.pad)
						flag_mismatch("tdata padding", want.pad, got.pad);
				end
			end
			if (s_tvalid && s_tready) begin
				cells_taken++;
				step_square_search(s_tdata, s_tlast);
			end
		end
	end

	// Write a register, track it in the predictor, then read it back
	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [31:0] mask;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_GRID_WIDTH) begin
			grid_width_reg = value[CFG_WIDTH_W-1:0];
			mask = 32'h7FF;
		end else begin
			obstacle_reg = value[CHAR_W-1:0];
			mask = 32'hFF;
		end
		reg_writes++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (value & mask))
			flag_mismatch("register readback", value & mask, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic queue_cell(input logic [7:0] ch, input logic last);
		cell_t c;
		c.ch = ch;
		c.last = last;
		cells_pending.push_back(c);
		cells_queued++;
	endtask

	// Queue full rows plus extra cells; flag the final one as last
	task automatic queue_grid(input int cols, input int rows, input int extra,
			input int block_pct, input bit free_tail);
		int n;
		logic [7:0] ch;
		n = cols * rows + extra;
		for (int i = 0; i < n; i++) begin
			ch = ($urandom_range(0, 99) < block_pct) ? obstacle_reg : 8'($urandom);
			if (free_tail && i == n - 1)
				ch = obstacle_reg ^ 8'h01;
			queue_cell(ch, i == n - 1);
		end
	endtask

	// Mostly well-formed grids, some ending mid-row, a few pure noise
	task automatic queue_random_grid(input int cols);
		int roll;
		int pct;
		roll = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: pct = 3;
			1: pct = 15;
			2: pct = 40;
			default: pct = 85;
		endcase
		if (roll < 80)
			queue_grid(cols, $urandom_range(1, (cols < 4) ? 12 : 6), 0, pct, 1'b0);
		else if (roll < 95)
			queue_grid(cols, $urandom_range(0, 4), $urandom_range(1, cols), pct, 1'b0);
		else
			queue_grid(cols, 0, $urandom_range(1, 3 * cols), 50, 1'b0);
	endtask

	// Wait until every cell is taken and every square has come out
	task automatic wait_idle();
		do @(negedge clk); while (cells_taken != cells_queued || squares_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int w;
		int roll;
		logic [7:0] obst;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset registers, width one, blocked middle cell
		src_idle_pct = 26;
		dst_idle_pct = 62;
		queue_cell(8'h61, 1'b0);
		queue_cell(8'd111, 1'b0);
		queue_cell(8'hFF, 1'b1);
		wait_idle();
		// 3x3 grid with obstacle code zero and extreme free codes
		write_reg(REG_GRID_WIDTH, 32'd3);
		write_reg(REG_OBSTACLE, 32'd0);
		queue_cell(8'hFF, 1'b0);
		queue_cell(8'h80, 1'b0);
		queue_cell(8'h01, 1'b0);
		queue_cell(8'h07, 1'b0);
		queue_cell(8'h40, 1'b0);
		queue_cell(8'h20, 1'b0);
		queue_cell(8'h00, 1'b0);
		queue_cell(8'h10, 1'b0);
		queue_cell(8'hFE, 1'b1);
		wait_idle();
		// no free cell at all
		write_reg(REG_OBSTACLE, 32'd255);
		repeat (3) queue_cell(8'hFF, 1'b0);
		queue_cell(8'hFF, 1'b1);
		wait_idle();
		// width zero acts as one
		write_reg(REG_GRID_WIDTH, 32'd0);
		write_reg(REG_OBSTACLE, 32'h80);
		queue_cell(8'h01, 1'b0);
		queue_cell(8'h02, 1'b0);
		queue_cell(8'h80, 1'b1);
		wait_idle();
		// shrink the width mid-row, past the current column
		write_reg(REG_GRID_WIDTH, 32'd5);
		repeat (4) queue_cell(8'h33, 1'b0);
		wait_idle();
		write_reg(REG_GRID_WIDTH, 32'd2);
		queue_cell(8'h34, 1'b0);
		queue_cell(8'h35, 1'b0);
		queue_cell(8'h36, 1'b1);
		wait_idle();

		// random grids under three idling regimes
		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 62 : 0;
			dst_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 26 : 0;
			while (cells_queued < (ITEMS - TAIL_ITEMS) * (mode + 1) / 3) begin
				roll = $urandom_range(0, 99);
				if (roll < 5)
					w = 0;
				else if (roll < 15)
					w = 1;
				else if (roll < 60)
					w = $urandom_range(2, 6);
				else if (roll < 90)
					w = $urandom_range(7, 16);
				else
					w = $urandom_range(17, 48);
				roll = $urandom_range(0, 99);
				obst = (roll < 10) ? 8'h00 : (roll < 20) ? 8'hFF : 8'($urandom);
				write_reg(REG_GRID_WIDTH, w);
				write_reg(REG_OBSTACLE, obst);
				repeat (4) queue_random_grid((w == 0) ? 1 : w);
				// fill the output while the sender keeps offering grids
				if (mode == 0 && !hold_req) begin
					hold_req = 1'b1;
					repeat (6) queue_grid(2, 2, 0, 10, 1'b0);
				end
				wait_idle();
			end
		end

		// width beyond the buffer: one widest row, then a few cells below it
		write_reg(REG_GRID_WIDTH, 32'd2047);
		write_reg(REG_OBSTACLE, 32'h2A);
		queue_grid(MAX_W, 1, 4, 2, 1'b0);
		wait_idle();

		$display("Checked %0d squares from %0d cells after %0d register writes.",
			squares_seen, cells_taken, reg_writes);
		$display("Widths 0 to 2047, obstacle codes 0 to 255, output hold-off, widest row.");
		if (mismatches == 0 && squares_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// End a hung run
	initial begin
		#RUN_LIMIT_NS;
		$display("FAIL");
		$finish;
	end

endmodule
